FILE: sv/mi3_pkg.sv
// shared types, constants and cofactor index tables for the 3x3 matrix inverter
// used by every module of the block, depends on nothing
package mi3_pkg;

  localparam int unsigned DW        = 32;
  localparam int unsigned NE        = 9;
  localparam int unsigned ADJ_W     = 65;
  localparam int unsigned PP_W      = 65;
  localparam int unsigned DET_W     = 98;
  localparam int unsigned MAG_W     = 97;
  localparam int unsigned THR_W     = 31;
  localparam int unsigned FRAC_W    = 16;
  localparam int unsigned DIV_STEPS = 32;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);
  localparam logic [DW-1:0]    Q_MAX     = 32'h7fff_ffff;
  localparam logic [DW-1:0]    Q_MIN     = 32'h8000_0000;

  // cofactor k = m[A]*m[B] - m[C]*m[D]
  localparam int COF_A [NE] = '{4, 2, 1, 5, 0, 2, 3, 1, 0};
  localparam int COF_B [NE] = '{8, 7, 5, 6, 8, 3, 7, 6, 4};
  localparam int COF_C [NE] = '{5, 1, 2, 3, 2, 0, 4, 0, 1};
  localparam int COF_D [NE] = '{7, 8, 4, 8, 6, 5, 6, 7, 3};

  typedef logic [NE-1:0][DW-1:0] mat_t;
  typedef logic [2:0][DW-1:0]    row_t;

  typedef struct packed {
    logic [2*NE-1:0][2*DW-1:0] prod;
    row_t                      row0;
  } prod_t;

  typedef struct packed {
    logic [NE-1:0][ADJ_W-1:0] adj;
    row_t                     row0;
  } adj_t;

  typedef struct packed {
    logic [2:0][PP_W-1:0]     pp_hi;
    logic [2:0][PP_W-1:0]     pp_lo;
    logic [NE-1:0][ADJ_W-1:0] adj;
  } pp_t;

  typedef struct packed {
    logic [2:0][DET_W-1:0]    term;
    logic [NE-1:0][ADJ_W-1:0] adj;
  } term_t;

  typedef struct packed {
    logic [DET_W-1:0]         det;
    logic [NE-1:0][ADJ_W-1:0] adj;
  } det_sum_t;

  typedef struct packed {
    logic [MAG_W-1:0]         dmag;
    logic                     det_neg;
    logic [NE-1:0][ADJ_W-1:0] amag;
    logic [NE-1:0]            adj_neg;
  } det_t;

  typedef struct packed {
    logic [MAG_W-1:0]         d;
    logic                     singular;
    logic [NE-1:0]            neg;
    logic [NE-1:0]            ovf;
    logic [NE-1:0][MAG_W-1:0] r;
    logic [NE-1:0][DW-1:0]    q;
  } div_t;

endpackage

FILE: sv/matrix_inverse_3x3.sv
// 3x3 matrix inverse by adjugate over determinant, signed q16.16, pipelined
// depends on mi3_pkg, mi3_cofactor, mi3_det, mi3_div_prep, mi3_div_step, mi3_out
//
// channel   direction  fields
// s_axis    in         tdata: a_00..a_22, 32 bits each, a_00 lowest
// m_axis    out        tdata: inv_00..inv_22, 32 bits each; tuser: singular, saturated
// cfg       in         wr_data: singular_threshold, 31 bits
//
// one transaction per cycle while m_axis_tready allows; 2 cofactor stages, 4 determinant
// stages, 1 prep stage, 32 quotient-bit stages, 1 output register
// each stage holds its own valid bit, so empty stages fill while the output is stalled
// rst clears all valid bits and sets the threshold to 1
module matrix_inverse_3x3 (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [287:0]  s_axis_tdata,   // a_00, a_01, a_02, a_10, a_11, a_12, a_20, a_21, a_22
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [287:0]  m_axis_tdata,   // inv_00, ..., inv_22
  output logic [1:0]    m_axis_tuser,   // singular, saturated
  input  logic          cfg_wr_en,
  input  logic [30:0]   cfg_wr_data
);

  localparam int unsigned NS = mi3_pkg::DIV_STEPS;

  logic [mi3_pkg::THR_W-1:0] thresh;
  logic                      c_valid;
  logic                      c_ready;
  mi3_pkg::adj_t             c_data;
  logic                      d_valid;
  logic                      d_ready;
  mi3_pkg::det_t             d_data;
  logic [NS:0]               q_valid;
  logic [NS:0]               q_ready;
  mi3_pkg::div_t             q_data [NS+1];

  always_ff @(posedge clk) begin
    if (rst) thresh <= mi3_pkg::THR_RESET;
    else if (cfg_wr_en) thresh <= cfg_wr_data;
  end

  mi3_cofactor u_cof (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_data  (c_data)
  );

  mi3_det u_det (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (c_valid),
    .in_ready  (c_ready),
    .in_data   (c_data),
    .out_valid (d_valid),
    .out_ready (d_ready),
    .out_data  (d_data)
  );

  mi3_div_prep u_prep (
    .clk       (clk),
    .rst       (rst),
    .thresh    (thresh),
    .in_valid  (d_valid),
    .in_ready  (d_ready),
    .in_data   (d_data),
    .out_valid (q_valid[0]),
    .out_ready (q_ready[0]),
    .out_data  (q_data[0])
  );

  for (genvar i = 0; i < NS; i++) begin : g_step
    mi3_div_step u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (q_valid[i]),
      .in_ready  (q_ready[i]),
      .in_data   (q_data[i]),
      .out_valid (q_valid[i+1]),
      .out_ready (q_ready[i+1]),
      .out_data  (q_data[i+1])
    );
  end

  mi3_out u_out (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid[NS]),
    .in_ready  (q_ready[NS]),
    .in_data   (q_data[NS]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_flags (m_axis_tuser)
  );

endmodule

FILE: sv/mi3_cofactor.sv
// two stages: 18 entry products, then the nine cofactors of the adjugate
// depends on mi3_pkg
module mi3_cofactor (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mi3_pkg::mat_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mi3_pkg::adj_t  out_data
);

  logic           v1;
  mi3_pkg::prod_t s1;
  mi3_pkg::prod_t s1_next;
  logic           v2;
  mi3_pkg::adj_t  s2;
  mi3_pkg::adj_t  s2_next;
  logic           ld1;
  logic           ld2;

  assign ld2       = !v2 || out_ready;
  assign ld1       = !v1 || ld2;
  assign in_ready  = ld1;
  assign out_valid = v2;
  assign out_data  = s2;

  always_comb begin
    for (int k = 0; k < mi3_pkg::NE; k++) begin
      s1_next.prod[2*k]   = $signed(in_data[mi3_pkg::COF_A[k]]) *
                            $signed(in_data[mi3_pkg::COF_B[k]]);
      s1_next.prod[2*k+1] = $signed(in_data[mi3_pkg::COF_C[k]]) *
                            $signed(in_data[mi3_pkg::COF_D[k]]);
    end
    s1_next.row0 = in_data[2:0];
  end

  always_comb begin
    for (int k = 0; k < mi3_pkg::NE; k++) begin
      s2_next.adj[k] = {s1.prod[2*k][2*mi3_pkg::DW-1], s1.prod[2*k]} -
                       {s1.prod[2*k+1][2*mi3_pkg::DW-1], s1.prod[2*k+1]};
    end
    s2_next.row0 = s1.row0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (ld1) v1 <= in_valid;
      if (ld2) v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) s1 <= s1_next;
    if (ld2) s2 <= s2_next;
  end

endmodule

FILE: sv/mi3_det.sv
// four stages: split products, shifted terms, determinant sum, magnitudes
// depends on mi3_pkg
module mi3_det (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mi3_pkg::adj_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mi3_pkg::det_t  out_data
);

  localparam int unsigned PW = mi3_pkg::PP_W;
  localparam int unsigned AW = mi3_pkg::ADJ_W;
  localparam int unsigned GW = mi3_pkg::DET_W;

  logic [3:0]          v;
  logic [3:0]          ld;
  mi3_pkg::pp_t        s3;
  mi3_pkg::pp_t        s3_next;
  mi3_pkg::term_t      s4;
  mi3_pkg::term_t      s4_next;
  mi3_pkg::det_sum_t   s5;
  mi3_pkg::det_sum_t   s5_next;
  mi3_pkg::det_t       s6;
  mi3_pkg::det_t       s6_next;
  logic [GW-1:0]       det_inv;
  logic [AW-1:0]       adj_inv;

  assign ld[3]     = !v[3] || out_ready;
  assign ld[2]     = !v[2] || ld[3];
  assign ld[1]     = !v[1] || ld[2];
  assign ld[0]     = !v[0] || ld[1];
  assign in_ready  = ld[0];
  assign out_valid = v[3];
  assign out_data  = s6;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s3_next.pp_hi[j] = PW'($signed(in_data.row0[j]) *
                             $signed(in_data.adj[3*j][AW-1:mi3_pkg::DW]));
      s3_next.pp_lo[j] = PW'($signed(in_data.row0[j]) *
                             $signed({1'b0, in_data.adj[3*j][mi3_pkg::DW-1:0]}));
    end
    s3_next.adj = in_data.adj;
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s4_next.term[j] = {s3.pp_hi[j][PW-1], s3.pp_hi[j], {mi3_pkg::DW{1'b0}}} +
                        {{(GW-PW){s3.pp_lo[j][PW-1]}}, s3.pp_lo[j]};
    end
    s4_next.adj = s3.adj;
  end

  always_comb begin
    s5_next.det = s4.term[0] + s4.term[1] + s4.term[2];
    s5_next.adj = s4.adj;
  end

  always_comb begin
    det_inv         = -s5.det;
    s6_next.det_neg = s5.det[GW-1];
    s6_next.dmag    = s5.det[GW-1] ? det_inv[mi3_pkg::MAG_W-1:0]
                                   : s5.det[mi3_pkg::MAG_W-1:0];
    adj_inv         = '0;
    for (int k = 0; k < mi3_pkg::NE; k++) begin
      adj_inv            = -s5.adj[k];
      s6_next.adj_neg[k] = s5.adj[k][AW-1];
      s6_next.amag[k]    = s5.adj[k][AW-1] ? adj_inv : s5.adj[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (ld[0]) v[0] <= in_valid;
      if (ld[1]) v[1] <= v[0];
      if (ld[2]) v[2] <= v[1];
      if (ld[3]) v[3] <= v[2];
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) s3 <= s3_next;
    if (ld[1]) s4 <= s4_next;
    if (ld[2]) s5 <= s5_next;
    if (ld[3]) s6 <= s6_next;
  end

endmodule

FILE: sv/mi3_div_prep.sv
// one stage: singular test, per-entry overflow test and divider start values
// depends on mi3_pkg
module mi3_div_prep (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [mi3_pkg::THR_W-1:0]   thresh,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  mi3_pkg::det_t               in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output mi3_pkg::div_t               out_data
);

  localparam int unsigned MW = mi3_pkg::MAG_W;

  logic           v;
  logic           ld;
  mi3_pkg::div_t  s;
  mi3_pkg::div_t  s_next;
  logic [MW-1:0]  tq;

  assign ld        = !v || out_ready;
  assign in_ready  = ld;
  assign out_valid = v;
  assign out_data  = s;

  always_comb begin
    tq = {{(MW - mi3_pkg::THR_W - mi3_pkg::DW){1'b0}}, thresh, {mi3_pkg::DW{1'b0}}};
    s_next.d        = in_data.dmag;
    s_next.singular = (in_data.dmag == '0) || (in_data.dmag < tq);
    for (int k = 0; k < mi3_pkg::NE; k++) begin
      s_next.neg[k] = in_data.adj_neg[k] ^ in_data.det_neg;
      s_next.r[k]   = {{(MW - mi3_pkg::ADJ_W){1'b0}}, in_data.amag[k]};
      s_next.ovf[k] = s_next.r[k] >= in_data.dmag;
      s_next.q[k]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= 1'b0;
    else if (ld) v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ld) s <= s_next;
  end

endmodule

FILE: sv/mi3_div_step.sv
// one restoring division step for all nine entries, one quotient bit each
// depends on mi3_pkg
module mi3_div_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mi3_pkg::div_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mi3_pkg::div_t  out_data
);

  localparam int unsigned MW = mi3_pkg::MAG_W;

  logic           v;
  logic           ld;
  mi3_pkg::div_t  s;
  mi3_pkg::div_t  s_next;
  logic [MW:0]    sh;
  logic [MW+1:0]  diff;

  assign ld        = !v || out_ready;
  assign in_ready  = ld;
  assign out_valid = v;
  assign out_data  = s;

  always_comb begin
    s_next = in_data;
    sh     = '0;
    diff   = '0;
    for (int k = 0; k < mi3_pkg::NE; k++) begin
      sh   = {in_data.r[k], 1'b0};
      diff = {1'b0, sh} - {2'b00, in_data.d};
      s_next.r[k] = diff[MW+1] ? sh[MW-1:0] : diff[MW-1:0];
      s_next.q[k] = {in_data.q[k][mi3_pkg::DW-2:0], !diff[MW+1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) v <= 1'b0;
    else if (ld) v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ld) s <= s_next;
  end

endmodule

FILE: sv/mi3_out.sv
// output register: sign, saturation, singular zeroing and flag packing
// depends on mi3_pkg
module mi3_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mi3_pkg::div_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output mi3_pkg::mat_t  out_data,
  output logic [1:0]     out_flags
);

  logic                               v;
  logic                               ld;
  mi3_pkg::mat_t                      ent;
  mi3_pkg::mat_t                      ent_next;
  logic [1:0]                         flags;
  logic [1:0]                         flags_next;
  logic [mi3_pkg::NE-1:0]             sat;

  assign ld        = !v || out_ready;
  assign in_ready  = ld;
  assign out_valid = v;
  assign out_data  = ent;
  assign out_flags = flags;

  always_comb begin
    for (int k = 0; k < mi3_pkg::NE; k++) begin
      if (in_data.neg[k]) begin
        sat[k]      = in_data.ovf[k] || (in_data.q[k] > mi3_pkg::Q_MIN);
        ent_next[k] = sat[k] ? mi3_pkg::Q_MIN : -in_data.q[k];
      end else begin
        sat[k]      = in_data.ovf[k] || in_data.q[k][mi3_pkg::DW-1];
        ent_next[k] = sat[k] ? mi3_pkg::Q_MAX : in_data.q[k];
      end
      if (in_data.singular) ent_next[k] = '0;
    end
    flags_next[0] = in_data.singular;
    flags_next[1] = !in_data.singular && (|sat);
  end

  always_ff @(posedge clk) begin
    if (rst) v <= 1'b0;
    else if (ld) v <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      ent   <= ent_next;
      flags <= flags_next;
    end
  end

endmodule
